// ===== rtl/vwsm_pkg.sv =====
// Shared types and constants for the vertex weld spatial match block.
package vwsm_pkg;

    localparam int MAX_KEPT    = 1024;
    localparam int IDX_W       = $clog2(MAX_KEPT);
    localparam int CNT_W       = IDX_W + 1;
    localparam int COORD_W     = 32;
    localparam int CELL_W      = COORD_W + 1;
    localparam int SOLID_W     = 16;
    localparam int RAD_W       = 31;
    localparam int DIVIDEND_W  = COORD_W + 1;
    localparam int DIVISOR_W   = RAD_W + 1;
    localparam int ACC_W       = 64;

    localparam logic [1:0] CFG_TOLERANCE = 2'd0;
    localparam logic [1:0] CFG_NEAREST   = 2'd1;
    localparam logic [1:0] CFG_SOLID     = 2'd2;

    localparam logic [RAD_W-1:0] TOL_RESET = RAD_W'(66);

    // One kept vertex as it sits in the store.
    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] z;
        logic signed [CELL_W-1:0]  cx;
        logic signed [CELL_W-1:0]  cy;
        logic signed [CELL_W-1:0]  cz;
        logic [SOLID_W-1:0]        solid;
        logic [RAD_W-1:0]          radius;
    } t_entry;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIV_GO,
        ST_DIV_WAIT,
        ST_RD,
        ST_CHK,
        ST_MX,
        ST_MY,
        ST_MZ,
        ST_MT,
        ST_DEC,
        ST_FIN
    } t_state;

endpackage

// ===== rtl/vertex_weld_spatial_match.sv =====
// Top level of the vertex weld spatial match block.
//
// A vertex is offered on the i_coord_*, i_solid_id, i_own_radius and
// i_radius_given ports and taken at the clock edge where start is high and
// busy is low. busy stays high until the cycle in which the result beat is
// shown, so the next vertex can be taken at the edge that ends that cycle.
// The result (o_merged_index, o_is_new, o_table_full) is on the ports for one
// cycle, marked by o_valid; the receiver cannot stall it.
// Sequence: three cell indices come from one shared bit-serial divider
// in turn, then the kept store is scanned one entry at a time through its
// registered read port. An entry that fails the cell, solid or per-axis
// test passes through the read and check states only; a candidate goes on
// through MX, MY, MZ, MT and DEC, the shared 31x31 multiplier forming
// three squares and the squared threshold in turn. A new vertex is taken
// only once the previous one has its result.
// Configuration writes use i_cfg_valid/o_cfg_ready with a register index and
// data; ready is always high and writes belong in idle time.
// Reset restores the default registers and empties the store; the store
// contents themselves are not cleared, since only entries below the fill
// count are ever read.
module vertex_weld_spatial_match (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic signed [vwsm_pkg::COORD_W-1:0]  i_coord_x,
    input  logic signed [vwsm_pkg::COORD_W-1:0]  i_coord_y,
    input  logic signed [vwsm_pkg::COORD_W-1:0]  i_coord_z,
    input  logic [vwsm_pkg::SOLID_W-1:0]         i_solid_id,
    input  logic [vwsm_pkg::RAD_W-1:0]           i_own_radius,
    input  logic                                 i_radius_given,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [1:0]                           i_cfg_index,
    input  logic [31:0]                          i_cfg_data,
    output logic                                 o_valid,
    output logic [vwsm_pkg::IDX_W-1:0]           o_merged_index,
    output logic                                 o_is_new,
    output logic                                 o_table_full
);
    import vwsm_pkg::*;

    localparam int MUL_W = RAD_W;
    localparam int DIFF_W = COORD_W + 1;

    // Configuration registers.
    logic [RAD_W-1:0] r_tol;
    logic             r_nearest;
    logic             r_solid_chk;

    // Control state.
    t_state          r_state, n_state;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] r_k;
    logic [1:0]       r_axis;
    logic             r_found;
    logic             r_valid;

    // Vertex being processed.
    logic signed [COORD_W-1:0] r_vx, r_vy, r_vz;
    logic [SOLID_W-1:0]        r_solid;
    logic [RAD_W-1:0]          r_ti;
    logic [RAD_W-1:0]          r_tu;
    logic signed [CELL_W-1:0]  r_cx, r_cy, r_cz;

    // Per entry working values.
    t_entry              mem [MAX_KEPT];
    t_entry              r_rd;
    logic [MUL_W-1:0]    r_ax, r_ay, r_az, r_thr;
    logic [4:0]          r_key;
    logic [2*MUL_W-1:0]  r_prod;
    logic [ACC_W-1:0]    r_acc;
    logic [ACC_W-1:0]    r_best_d2;
    logic [4:0]          r_best_key;
    logic [IDX_W-1:0]    r_best;

    // Result registers.
    logic [IDX_W-1:0] r_out_idx;
    logic             r_out_new;
    logic             r_out_full;

    // Divider hookup.
    logic                  div_start;
    logic                  div_done;
    logic [DIVIDEND_W-1:0] div_quot;
    logic [DIVIDEND_W-1:0] div_dividend;
    logic [DIVISOR_W-1:0]  div_divisor;
    logic signed [COORD_W-1:0] axis_v;
    logic [COORD_W-1:0]    axis_mag;

    // Candidate check signals.
    logic signed [CELL_W:0]  dcx, dcy, dcz;
    logic                    near_x, near_y, near_z;
    logic signed [DIFF_W-1:0] dx, dy, dz;
    logic [DIFF_W-1:0]       mx, my, mz;
    logic [RAD_W-1:0]        thr;
    logic                    cand;
    logic [4:0]              key;
    logic                    last;
    logic                    better;
    logic                    mem_we;
    logic [MUL_W-1:0]        mul_a;
    logic signed [CELL_W-1:0] cell_val;

    // Zero tolerance acts as one.
    logic [RAD_W-1:0] tol_eff;
    assign tol_eff = (r_tol == '0) ? RAD_W'(1) : r_tol;

    // Cell division operands for the current axis: (2|v| + t) / 2t.
    always_comb begin
        case (r_axis)
            2'd0:    axis_v = r_vx;
            2'd1:    axis_v = r_vy;
            default: axis_v = r_vz;
        endcase
        axis_mag     = axis_v[COORD_W-1] ? COORD_W'(-axis_v) : COORD_W'(axis_v);
        div_dividend = {axis_mag, 1'b0} + DIVIDEND_W'(r_tu);
        div_divisor  = {r_tu, 1'b0};
        cell_val     = axis_v[COORD_W-1] ? CELL_W'(-$signed(div_quot))
                                         : CELL_W'($signed(div_quot));
    end

    vwsm_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_done     (div_done),
        .o_quot     (div_quot)
    );

    // Candidate test on the registered store entry.
    always_comb begin
        dcx    = {r_rd.cx[CELL_W-1], r_rd.cx} - {r_cx[CELL_W-1], r_cx};
        dcy    = {r_rd.cy[CELL_W-1], r_rd.cy} - {r_cy[CELL_W-1], r_cy};
        dcz    = {r_rd.cz[CELL_W-1], r_rd.cz} - {r_cz[CELL_W-1], r_cz};
        near_x = (dcx >= -1) && (dcx <= 1);
        near_y = (dcy >= -1) && (dcy <= 1);
        near_z = (dcz >= -1) && (dcz <= 1);
        dx     = {r_rd.x[COORD_W-1], r_rd.x} - {r_vx[COORD_W-1], r_vx};
        dy     = {r_rd.y[COORD_W-1], r_rd.y} - {r_vy[COORD_W-1], r_vy};
        dz     = {r_rd.z[COORD_W-1], r_rd.z} - {r_vz[COORD_W-1], r_vz};
        mx     = dx[DIFF_W-1] ? DIFF_W'(-dx) : DIFF_W'(dx);
        my     = dy[DIFF_W-1] ? DIFF_W'(-dy) : DIFF_W'(dy);
        mz     = dz[DIFF_W-1] ? DIFF_W'(-dz) : DIFF_W'(dz);
        if (r_nearest) begin
            thr = (r_ti > r_rd.radius) ? r_ti : r_rd.radius;
        end else begin
            thr = r_tu;
        end
        cand = near_x && near_y && near_z
            && (!r_solid_chk || (r_rd.solid == r_solid))
            && (mx <= DIFF_W'(thr)) && (my <= DIFF_W'(thr)) && (mz <= DIFF_W'(thr));
        // Offsets map -1,0,1 onto 0,1,2; the key orders dz, dy, dx.
        key = 5'(({3'b0, 2'(dcz[1:0] + 2'd1)} * 5'd9)
                + ({3'b0, 2'(dcy[1:0] + 2'd1)} * 5'd3)
                + {3'b0, 2'(dcx[1:0] + 2'd1)});
        last = (r_k + CNT_W'(1)) >= r_count;
    end

    // Choice between the new match and the best so far.
    always_comb begin
        if (!r_found) begin
            better = 1'b1;
        end else if (r_nearest) begin
            better = (r_acc < r_best_d2) || ((r_acc == r_best_d2) && (r_key < r_best_key));
        end else begin
            better = r_key < r_best_key;
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:     if (start) n_state = ST_DIV_GO;
            ST_DIV_GO:   n_state = ST_DIV_WAIT;
            ST_DIV_WAIT: begin
                if (div_done) begin
                    if (r_axis != 2'd2) begin
                        n_state = ST_DIV_GO;
                    end else if (r_count == '0) begin
                        n_state = ST_FIN;
                    end else begin
                        n_state = ST_RD;
                    end
                end
            end
            ST_RD:       n_state = ST_CHK;
            ST_CHK: begin
                if (cand) begin
                    n_state = ST_MX;
                end else begin
                    n_state = last ? ST_FIN : ST_RD;
                end
            end
            ST_MX:       n_state = ST_MY;
            ST_MY:       n_state = ST_MZ;
            ST_MZ:       n_state = ST_MT;
            ST_MT:       n_state = ST_DEC;
            ST_DEC:      n_state = last ? ST_FIN : ST_RD;
            ST_FIN:      n_state = ST_IDLE;
            default:     n_state = ST_IDLE;
        endcase
    end

    // Control outputs of the sequencer.
    always_comb begin
        div_start = 1'b0;
        mem_we    = 1'b0;
        mul_a     = r_ax;
        case (r_state)
            ST_DIV_GO: div_start = 1'b1;
            ST_MX:     mul_a = r_ax;
            ST_MY:     mul_a = r_ay;
            ST_MZ:     mul_a = r_az;
            ST_MT:     mul_a = r_thr;
            ST_FIN:    mem_we = !r_found && (r_count != CNT_W'(MAX_KEPT));
            default:   mul_a = r_ax;
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_valid     <= 1'b0;
            r_tol       <= TOL_RESET;
            r_nearest   <= 1'b0;
            r_solid_chk <= 1'b0;
        end else begin
            r_state <= n_state;
            r_valid <= (r_state == ST_FIN);
            if (mem_we) r_count <= r_count + CNT_W'(1);
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_TOLERANCE: r_tol       <= i_cfg_data[RAD_W-1:0];
                    CFG_NEAREST:   r_nearest   <= i_cfg_data[0];
                    CFG_SOLID:     r_solid_chk <= i_cfg_data[0];
                    default:       r_tol       <= r_tol;
                endcase
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                r_vx    <= i_coord_x;
                r_vy    <= i_coord_y;
                r_vz    <= i_coord_z;
                r_solid <= i_solid_id;
                r_tu    <= tol_eff;
                r_ti    <= i_radius_given ? i_own_radius : tol_eff;
                r_axis  <= 2'd0;
                r_k     <= '0;
                r_found <= 1'b0;
            end
            ST_DIV_WAIT: begin
                if (div_done) begin
                    case (r_axis)
                        2'd0:    r_cx <= cell_val;
                        2'd1:    r_cy <= cell_val;
                        default: r_cz <= cell_val;
                    endcase
                    r_axis <= r_axis + 2'd1;
                end
            end
            ST_RD: r_rd <= mem[r_k[IDX_W-1:0]];
            ST_CHK: begin
                r_ax  <= mx[MUL_W-1:0];
                r_ay  <= my[MUL_W-1:0];
                r_az  <= mz[MUL_W-1:0];
                r_thr <= thr;
                r_key <= key;
                if (!cand) r_k <= r_k + CNT_W'(1);
            end
            ST_MX: r_prod <= mul_a * mul_a;
            ST_MY: begin
                r_acc  <= ACC_W'(r_prod);
                r_prod <= mul_a * mul_a;
            end
            ST_MZ, ST_MT: begin
                r_acc  <= r_acc + ACC_W'(r_prod);
                r_prod <= mul_a * mul_a;
            end
            ST_DEC: begin
                // r_prod now holds the squared threshold.
                if ((r_acc <= ACC_W'(r_prod)) && better) begin
                    r_found    <= 1'b1;
                    r_best     <= r_k[IDX_W-1:0];
                    r_best_d2  <= r_acc;
                    r_best_key <= r_key;
                end
                r_k <= r_k + CNT_W'(1);
            end
            ST_FIN: begin
                if (r_found) begin
                    r_out_idx  <= r_best;
                    r_out_new  <= 1'b0;
                    r_out_full <= 1'b0;
                end else if (r_count == CNT_W'(MAX_KEPT)) begin
                    r_out_idx  <= '0;
                    r_out_new  <= 1'b0;
                    r_out_full <= 1'b1;
                end else begin
                    r_out_idx  <= r_count[IDX_W-1:0];
                    r_out_new  <= 1'b1;
                    r_out_full <= 1'b0;
                end
            end
            default: r_prod <= r_prod;
        endcase
    end

    // Kept vertex store: append at the fill count.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[r_count[IDX_W-1:0]] <= '{x: r_vx, y: r_vy, z: r_vz,
                                         cx: r_cx, cy: r_cy, cz: r_cz,
                                         solid: r_solid, radius: r_ti};
        end
    end

    assign busy           = (r_state != ST_IDLE);
    assign o_cfg_ready    = 1'b1;
    assign o_valid        = r_valid;
    assign o_merged_index = r_out_idx;
    assign o_is_new       = r_out_new;
    assign o_table_full   = r_out_full;

endmodule

// ===== rtl/vwsm_div.sv =====
// Restoring divider, one quotient bit per cycle, used for the cell indices.
module vwsm_div (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic [vwsm_pkg::DIVIDEND_W-1:0]   i_dividend,
    input  logic [vwsm_pkg::DIVISOR_W-1:0]    i_divisor,
    output logic                              o_done,
    output logic [vwsm_pkg::DIVIDEND_W-1:0]   o_quot
);
    import vwsm_pkg::*;

    localparam int STEP_W = $clog2(DIVIDEND_W + 1);

    logic [DIVISOR_W-1:0]  r_rem;
    logic [DIVIDEND_W-1:0] r_quot;
    logic [DIVISOR_W-1:0]  r_div;
    logic [STEP_W-1:0]     r_step;
    logic                  r_run;
    logic                  r_done;
    logic [DIVISOR_W:0]    trial;
    logic                  fits;

    // Shift the next dividend bit into the partial remainder and try a subtract.
    always_comb begin
        trial = {r_rem, r_quot[DIVIDEND_W-1]};
        fits  = trial >= {1'b0, r_div};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_run  <= 1'b1;
                r_step <= '0;
            end else if (r_run) begin
                r_step <= r_step + STEP_W'(1);
                if (r_step == STEP_W'(DIVIDEND_W - 1)) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Datapath registers carry no reset.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= '0;
            r_quot <= i_dividend;
            r_div  <= i_divisor;
        end else if (r_run) begin
            r_rem  <= fits ? DIVISOR_W'(trial - {1'b0, r_div}) : trial[DIVISOR_W-1:0];
            r_quot <= {r_quot[DIVIDEND_W-2:0], fits};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

// ===== tb/sv/vwsm_checker.sv =====
// Checker for the vertex weld block: predicts every merge result and compares it.
module vwsm_checker (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 start,
    input  logic                                 busy,
    input  logic signed [vwsm_pkg::COORD_W-1:0]  i_coord_x,
    input  logic signed [vwsm_pkg::COORD_W-1:0]  i_coord_y,
    input  logic signed [vwsm_pkg::COORD_W-1:0]  i_coord_z,
    input  logic [vwsm_pkg::SOLID_W-1:0]         i_solid_id,
    input  logic [vwsm_pkg::RAD_W-1:0]           i_own_radius,
    input  logic                                 i_radius_given,
    input  logic                                 i_cfg_valid,
    input  logic                                 o_cfg_ready,
    input  logic [1:0]                           i_cfg_index,
    input  logic [31:0]                          i_cfg_data,
    input  logic                                 o_valid,
    input  logic [vwsm_pkg::IDX_W-1:0]           o_merged_index,
    input  logic                                 o_is_new,
    input  logic                                 o_table_full,
    output int                                   o_fail_count,
    output int                                   o_pending
);
    import vwsm_pkg::*;

    typedef struct {
        logic [IDX_W-1:0] index;
        logic             is_new;
        logic             full;
    } t_merge;

    t_merge merge_queue[$];

    // Shadow of the kept store and the registers.
    longint           store_x[MAX_KEPT];
    longint           store_y[MAX_KEPT];
    longint           store_z[MAX_KEPT];
    longint           store_cx[MAX_KEPT];
    longint           store_cy[MAX_KEPT];
    longint           store_cz[MAX_KEPT];
    logic [SOLID_W-1:0] store_solid[MAX_KEPT];
    longint           store_rad[MAX_KEPT];
    int               store_fill;
    longint           tolerance;
    logic             nearest;
    logic             solid_only;

    assign o_pending = merge_queue.size();

    // Rounds v / t to the nearest integer, halves away from zero.
    function automatic longint cell_round(longint v, longint t);
        longint a;
        longint q;
        a = (v < 0) ? -v : v;
        q = (2 * a + t) / (2 * t);
        return (v < 0) ? -q : q;
    endfunction

    function automatic longint dist_abs(longint a, longint b);
        return (a >= b) ? a - b : b - a;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
        o_fail_count++;
    endtask

    // Works out where one vertex merges and updates the shadow store.
    function automatic t_merge weld_predict(longint vx, longint vy, longint vz,
                                            logic [SOLID_W-1:0] solid, longint rad,
                                            logic given);
        t_merge     r;
        longint     tol;
        longint     ti;
        longint     cx;
        longint     cy;
        longint     cz;
        longint     dx;
        longint     dy;
        longint     dz;
        longint     thr;
        longint     ax;
        longint     ay;
        longint     az;
        logic [63:0] d2;
        logic [63:0] best_d2;
        int         key;
        int         best_key;
        int         best;
        bit         found;
        tol = (tolerance == 0) ? 1 : tolerance;
        ti  = given ? rad : tol;
        cx  = cell_round(vx, tol);
        cy  = cell_round(vy, tol);
        cz  = cell_round(vz, tol);
        found = 0;
        best = 0;
        best_d2 = 0;
        best_key = 0;
        for (int k = 0; k < store_fill; k++) begin
            dx = store_cx[k] - cx;
            dy = store_cy[k] - cy;
            dz = store_cz[k] - cz;
            if (dx < -1 || dx > 1 || dy < -1 || dy > 1 || dz < -1 || dz > 1) continue;
            if (solid_only && store_solid[k] != solid) continue;
            thr = tol;
            if (nearest) thr = (ti > store_rad[k]) ? ti : store_rad[k];
            ax = dist_abs(store_x[k], vx);
            ay = dist_abs(store_y[k], vy);
            az = dist_abs(store_z[k], vz);
            if (ax > thr || ay > thr || az > thr) continue;
            d2 = 64'(ax) * 64'(ax) + 64'(ay) * 64'(ay) + 64'(az) * 64'(az);
            if (d2 > 64'(thr) * 64'(thr)) continue;
            key = int'((dz + 1) * 9 + (dy + 1) * 3 + (dx + 1));
            if (!found) begin
                found = 1; best = k; best_d2 = d2; best_key = key;
            end else if (nearest) begin
                if (d2 < best_d2 || (d2 == best_d2 && key < best_key)) begin
                    best = k; best_d2 = d2; best_key = key;
                end
            end else if (key < best_key) begin
                best = k; best_key = key;
            end
        end
        if (found) begin
            r.index = IDX_W'(best); r.is_new = 0; r.full = 0;
        end else if (store_fill >= MAX_KEPT) begin
            r.index = '0; r.is_new = 0; r.full = 1;
        end else begin
            store_x[store_fill] = vx;
            store_y[store_fill] = vy;
            store_z[store_fill] = vz;
            store_cx[store_fill] = cx;
            store_cy[store_fill] = cy;
            store_cz[store_fill] = cz;
            store_solid[store_fill] = solid;
            store_rad[store_fill] = ti;
            r.index = IDX_W'(store_fill); r.is_new = 1; r.full = 0;
            store_fill++;
        end
        return r;
    endfunction

    initial o_fail_count = 0;

    // Result beats are checked before a vertex taken at the same edge is predicted.
    always @(posedge i_clk) begin
        t_merge want;
        if (!i_rst_n) begin
            store_fill = 0;
            tolerance = 66;
            nearest = 0;
            solid_only = 0;
            merge_queue.delete();
        end else begin
            if (o_valid) begin
                if (merge_queue.size() == 0) begin
                    report_mismatch("unexpected result, index", o_merged_index, -1);
                end else begin
                    want = merge_queue.pop_front();
                    if (o_merged_index !== want.index)
                        report_mismatch("merged_index", o_merged_index, want.index);
                    if (o_is_new !== want.is_new)
                        report_mismatch("is_new", o_is_new, want.is_new);
                    if (o_table_full !== want.full)
                        report_mismatch("table_full", o_table_full, want.full);
                end
            end
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_TOLERANCE: tolerance = longint'(i_cfg_data[30:0]);
                    CFG_NEAREST:   nearest = i_cfg_data[0];
                    CFG_SOLID:     solid_only = i_cfg_data[0];
                    default: ;
                endcase
            end
            if (start && !busy) begin
                merge_queue.insert(merge_queue.size(),
                                   weld_predict(longint'(i_coord_x), longint'(i_coord_y),
                                                longint'(i_coord_z), i_solid_id,
                                                longint'(i_own_radius), i_radius_given));
            end
        end
    end

endmodule

// ===== tb/sv/testbench.sv =====
// Top of the vertex weld testbench: clock, reset, vertex and register stimulus, verdict.
module testbench;
    import vwsm_pkg::*;

    localparam longint CYCLE_LIMIT = 64'd60_000_000;

    logic                       i_clk;
    logic                       i_rst_n;
    logic                       start;
    logic                       busy;
    logic signed [COORD_W-1:0]  i_coord_x;
    logic signed [COORD_W-1:0]  i_coord_y;
    logic signed [COORD_W-1:0]  i_coord_z;
    logic [SOLID_W-1:0]         i_solid_id;
    logic [RAD_W-1:0]           i_own_radius;
    logic                       i_radius_given;
    logic                       i_cfg_valid;
    logic                       o_cfg_ready;
    logic [1:0]                 i_cfg_index;
    logic [31:0]                i_cfg_data;
    logic                       o_valid;
    logic [IDX_W-1:0]           o_merged_index;
    logic                       o_is_new;
    logic                       o_table_full;
    int                         fail_count;
    int                         pending;
    longint                     cycle_count;
    bit                         calm;
    longint                     cur_tol;
    longint                     seeds_x[$];
    longint                     seeds_y[$];
    longint                     seeds_z[$];
    logic [SOLID_W-1:0]         seeds_s[$];

    vertex_weld_spatial_match i_dut (.*);

    vwsm_checker i_checker (
        .i_clk, .i_rst_n, .start, .busy, .i_coord_x, .i_coord_y, .i_coord_z,
        .i_solid_id, .i_own_radius, .i_radius_given, .i_cfg_valid, .o_cfg_ready,
        .i_cfg_index, .i_cfg_data, .o_valid, .o_merged_index, .o_is_new, .o_table_full,
        .o_fail_count(fail_count), .o_pending(pending)
    );

    initial begin
        i_clk = 0;
        forever #6 i_clk = ~i_clk;
    end

    // Watchdog on the whole run.
    initial cycle_count = 0;
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Offers one vertex and returns at the falling edge after it was taken.
    task automatic send_vertex(input longint x, input longint y, input longint z,
                               input logic [SOLID_W-1:0] solid, input longint rad,
                               input logic given);
        if (!calm && $urandom_range(0, 99) < 26) begin
            start = 0;
            repeat ($urandom_range(1, 20)) @(negedge i_clk);
        end
        i_coord_x = COORD_W'(x);
        i_coord_y = COORD_W'(y);
        i_coord_z = COORD_W'(z);
        i_solid_id = solid;
        i_own_radius = RAD_W'(rad);
        i_radius_given = given;
        start = 1;
        while (busy) @(negedge i_clk);
        @(negedge i_clk);
    endtask

    // Register write beat, only once all results are in.
    task automatic write_reg(input logic [1:0] idx, input longint value);
        start = 0;
        while (pending != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
        i_cfg_valid = 1;
        i_cfg_index = idx;
        i_cfg_data = 32'(value);
        while (!o_cfg_ready) @(negedge i_clk);
        @(negedge i_clk);
        i_cfg_valid = 0;
        if (idx == CFG_TOLERANCE) cur_tol = (value[30:0] == 0) ? 1 : longint'(value[30:0]);
    endtask

    task automatic set_mode(input longint tol, input bit near, input bit solid);
        write_reg(CFG_TOLERANCE, tol);
        write_reg(CFG_NEAREST, near);
        write_reg(CFG_SOLID, solid);
    endtask

    // One random vertex: mostly welds around earlier seeds, some new seeds and noise.
    task automatic random_vertex();
        int     pick;
        int     s;
        longint span;
        longint x;
        longint y;
        longint z;
        longint rad;
        logic [SOLID_W-1:0] solid;
        pick = $urandom_range(0, 99);
        span = cur_tol + cur_tol / 2 + 1;
        if (span > 64'h7FFF_FFFF) span = 64'h7FFF_FFFF;
        rad = ($urandom_range(0, 3) == 0) ? longint'($urandom() >> 1)
                                          : longint'($urandom_range(0, 32'(span)));
        if (pick < 20 || seeds_x.size() == 0) begin
            x = longint'($signed($urandom()));
            y = longint'($signed($urandom()));
            z = longint'($signed($urandom()));
            solid = 16'($urandom_range(0, 3));
            seeds_x = {seeds_x, x}; seeds_y = {seeds_y, y}; seeds_z = {seeds_z, z};
            seeds_s = {seeds_s, solid};
            send_vertex(x, y, z, solid, rad, $urandom_range(0, 1));
        end else if (pick < 32) begin
            send_vertex($signed($urandom()), $signed($urandom()), $signed($urandom()),
                        16'($urandom()), longint'($urandom() >> 1), $urandom_range(0, 1));
        end else begin
            s = $urandom_range(0, seeds_x.size() - 1);
            x = seeds_x[s];
            y = seeds_y[s];
            z = seeds_z[s];
            if (pick >= 42) begin
                x += longint'($urandom_range(0, 32'(2 * span))) - span;
                y += longint'($urandom_range(0, 32'(2 * span))) - span;
                z += longint'($urandom_range(0, 32'(2 * span))) - span;
            end
            solid = ($urandom_range(0, 4) == 0) ? 16'($urandom_range(0, 3)) : seeds_s[s];
            send_vertex(x, y, z, solid, rad, $urandom_range(0, 1));
        end
    endtask

    initial begin
        start = 0;
        i_coord_x = '0;
        i_coord_y = '0;
        i_coord_z = '0;
        i_solid_id = '0;
        i_own_radius = '0;
        i_radius_given = 0;
        i_cfg_valid = 0;
        i_cfg_index = CFG_TOLERANCE;
        i_cfg_data = '0;
        i_rst_n = 0;
        calm = 0;
        cur_tol = 66;
        repeat (9) @(negedge i_clk);
        i_rst_n = 1;
        @(negedge i_clk);

        // Directed part under the reset settings: lowest cell key wins, tolerance of 66.
        send_vertex(0, 0, 0, 0, 0, 0);
        send_vertex(10, 10, 10, 0, 0, 0);
        send_vertex(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'hFFFF, 0, 0);
        send_vertex(-64'sd2147483648, -64'sd2147483648, -64'sd2147483648, 16'hFFFF,
                    32'h7FFF_FFFF, 1);
        send_vertex(66, 0, 0, 1, 0, 0);
        send_vertex(67, 0, 0, 1, 0, 0);
        send_vertex(-33, 0, 0, 2, 0, 0);
        send_vertex(99, 0, 0, 2, 0, 0);
        // Vertices of another solid no longer merge.
        write_reg(CFG_SOLID, 1);
        send_vertex(0, 0, 0, 5, 0, 0);
        send_vertex(1, 1, 1, 5, 0, 0);
        // Nearest mode with given radii, including an exact tie between two entries.
        write_reg(CFG_NEAREST, 1);
        send_vertex(200, 0, 0, 7, 100, 1);
        send_vertex(300, 0, 0, 7, 100, 1);
        send_vertex(250, 0, 0, 7, 60, 1);
        send_vertex(260, 5, 0, 7, 0, 0);
        send_vertex(400, 0, 0, 7, 32'h7FFF_FFFF, 1);
        // A tolerance of zero behaves as one.
        set_mode(0, 0, 0);
        send_vertex(3, 3, 3, 9, 0, 0);
        send_vertex(4, 3, 3, 9, 0, 0);
        send_vertex(5, 4, 2, 9, 0, 0);
        // Largest tolerance: differences beyond it never merge.
        set_mode(32'h7FFF_FFFF, 0, 0);
        send_vertex(32'h7FFF_FFFF, 0, 0, 3, 0, 0);
        send_vertex(-64'sd2147483648, 0, 0, 3, 0, 0);
        send_vertex(0, 32'h4000_0000, -1073741824, 3, 0, 0);

        // Random phases over several settings.
        set_mode(longint'($urandom_range(1, 32'h0010_0000)), 0, 0);
        repeat (140) random_vertex();
        set_mode(1, 1, 1);
        repeat (40) random_vertex();
        calm = 1;
        repeat (50) random_vertex();
        calm = 0;
        repeat (50) random_vertex();
        set_mode(32'h7FFF_FFFF, 0, 1);
        repeat (140) random_vertex();
        set_mode(longint'($urandom_range(16, 32'h0100_0000)), 1, 0);
        repeat (120) random_vertex();
        start = 0;

        while (pending != 0) @(negedge i_clk);
        repeat (200) @(negedge i_clk);
        if (fail_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/vwsm_pkg.sv
rtl/vwsm_div.sv
rtl/vertex_weld_spatial_match.sv
tb/sv/vwsm_checker.sv
tb/sv/testbench.sv
